// ===== src/assert_macros.svh =====
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_IMPL(name, clk, rstn, pre, post, msg)
`define ASSERT_NEXT(name, clk, rstn, pre, post, msg)
`endif

`endif

// ===== src/lstrm_pkg.sv =====
`timescale 1ns / 1ps
package lstrm_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 11;
    localparam int IDX_W = 10;
    localparam int ACT_W = 2;

    localparam logic [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_RST = 11'd1024;

    localparam logic [ACT_W-1:0] ACT_SET   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // frame progress in the range walk
    localparam logic [1:0] STG_ENTER = 2'd0;
    localparam logic [1:0] STG_LEFT  = 2'd1;
    localparam logic [1:0] STG_RIGHT = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_START,
        OP_PRD_TOP,
        OP_PRD_C1,
        OP_PRD_C2,
        OP_PGET,
        OP_PSETV,
        OP_PAPPLY,
        OP_PC1,
        OP_PC2,
        OP_LEAFWR,
        OP_DESCEND,
        OP_POP,
        OP_PUSH_C1,
        OP_PUSH_C2,
        OP_ACC,
        OP_RC1,
        OP_RC2,
        OP_RCW,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic       do_set;
        logic       do_add;
        logic       do_query;
        logic       q_empty;
        logic       p_zero;
        logic       tgt_leaf;
        logic       top_leaf;
        logic       disjoint;
        logic       covered;
        logic [1:0] stage;
        logic       sp_one;
        logic       out_busy;
    } sts_t;

    function automatic logic [VAL_W-1:0] smax(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
        return ($signed(a) >= $signed(b)) ? a : b;
    endfunction

endpackage

// ===== src/lstrm_ram.sv =====
`timescale 1ns / 1ps
module lstrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lstrm_ctrl.sv =====
`timescale 1ns / 1ps
module lstrm_ctrl
    import lstrm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [18:0] {
        S_CLEAR   = 19'h00001,
        S_IDLE    = 19'h00002,
        S_DECIDE  = 19'h00004,
        S_SET_TOP = 19'h00008,
        S_SET_AFT = 19'h00010,
        S_SET_C2  = 19'h00020,
        S_SET_DN  = 19'h00040,
        S_SET_POP = 19'h00080,
        S_SET_RC  = 19'h00100,
        S_RW_TOP  = 19'h00200,
        S_RW_S0   = 19'h00400,
        S_RW_POP  = 19'h00800,
        S_PGET    = 19'h01000,
        S_PAPPLY  = 19'h02000,
        S_PC1     = 19'h04000,
        S_PC2     = 19'h08000,
        S_RC2     = 19'h10000,
        S_RCW     = 19'h20000,
        S_FIN     = 19'h40000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (sts.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_START;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (sts.do_set) begin
                    state_next = S_SET_TOP;
                end else if (sts.do_add) begin
                    state_next = S_RW_TOP;
                end else if (sts.do_query) begin
                    state_next = sts.q_empty ? S_FIN : S_RW_TOP;
                end else begin
                    state_next = S_IDLE;
                end
            end
            // point update: push down along the path, write leaf, fix ancestors
            S_SET_TOP: begin
                cmd.op     = OP_PRD_TOP;
                ret_next   = S_SET_AFT;
                state_next = S_PGET;
            end
            S_SET_AFT: begin
                if (sts.top_leaf) begin
                    cmd.op     = OP_LEAFWR;
                    state_next = S_SET_POP;
                end else begin
                    cmd.op     = OP_PRD_C1;
                    ret_next   = S_SET_C2;
                    state_next = S_PGET;
                end
            end
            S_SET_C2: begin
                cmd.op     = OP_PRD_C2;
                ret_next   = S_SET_DN;
                state_next = S_PGET;
            end
            S_SET_DN: begin
                cmd.op     = OP_DESCEND;
                state_next = S_SET_TOP;
            end
            S_SET_POP: begin
                cmd.op     = OP_POP;
                state_next = sts.sp_one ? S_IDLE : S_SET_RC;
            end
            S_SET_RC: begin
                cmd.op     = OP_RC1;
                ret_next   = S_SET_POP;
                state_next = S_RC2;
            end
            // range walk over the frame stack
            S_RW_TOP: begin
                unique case (sts.stage)
                    STG_ENTER: begin
                        cmd.op     = OP_PRD_TOP;
                        ret_next   = S_RW_S0;
                        state_next = S_PGET;
                    end
                    STG_LEFT: begin
                        cmd.op     = OP_PUSH_C2;
                        state_next = S_RW_TOP;
                    end
                    default: begin
                        if (sts.do_add) begin
                            cmd.op     = OP_RC1;
                            ret_next   = S_RW_POP;
                            state_next = S_RC2;
                        end else begin
                            state_next = S_RW_POP;
                        end
                    end
                endcase
            end
            S_RW_S0: begin
                priority if (sts.disjoint) begin
                    state_next = S_RW_POP;
                end else if (sts.covered) begin
                    if (sts.do_add) begin
                        cmd.op     = OP_PSETV;
                        ret_next   = S_RW_POP;
                        state_next = S_PAPPLY;
                    end else begin
                        cmd.op     = OP_ACC;
                        state_next = S_RW_POP;
                    end
                end else begin
                    cmd.op     = OP_PUSH_C1;
                    state_next = S_RW_TOP;
                end
            end
            S_RW_POP: begin
                cmd.op = OP_POP;
                if (sts.sp_one) begin
                    state_next = sts.do_add ? S_IDLE : S_FIN;
                end else begin
                    state_next = S_RW_TOP;
                end
            end
            // pending-add push down of the target node
            S_PGET: begin
                cmd.op     = OP_PGET;
                state_next = S_PAPPLY;
            end
            S_PAPPLY: begin
                if (sts.p_zero) begin
                    state_next = ret_reg;
                end else begin
                    cmd.op     = OP_PAPPLY;
                    state_next = sts.tgt_leaf ? ret_reg : S_PC1;
                end
            end
            S_PC1: begin
                cmd.op     = OP_PC1;
                state_next = S_PC2;
            end
            S_PC2: begin
                cmd.op     = OP_PC2;
                state_next = ret_reg;
            end
            // recompute the top frame's maximum from its children
            S_RC2: begin
                cmd.op     = OP_RC2;
                state_next = S_RCW;
            end
            S_RCW: begin
                cmd.op     = OP_RCW;
                state_next = ret_reg;
            end
            S_FIN: begin
                if (!sts.out_busy) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lstrm_dp.sv =====
`timescale 1ns / 1ps
module lstrm_dp
    import lstrm_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int NODE_COUNT   = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic [CNT_W-1:0] element_count,
    input  logic [55:0]      s_tdata,
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic [0:0]       m_tuser
);

    localparam int NODE_W    = $clog2(NODE_COUNT);
    localparam int NW        = (NODE_W > 13) ? NODE_W : 13;
    localparam int LG        = $clog2(MAX_ELEMENTS);
    localparam int STK_DEPTH = (LG > 11) ? 12 : LG + 1;
    localparam int IX_W      = $clog2(STK_DEPTH);
    localparam int SP_W      = $clog2(STK_DEPTH + 1);
    localparam logic [NW:0]        NODE_LIM = (NW+1)'(NODE_COUNT);
    localparam logic [NODE_W-1:0]  CLR_LAST = NODE_W'(NODE_COUNT - 1);

    typedef struct packed {
        logic [NW-1:0]    node;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [1:0]       stage;
    } frame_t;

    frame_t           stk_reg [STK_DEPTH];
    logic [SP_W-1:0]  sp_reg;
    logic [NODE_W-1:0] clr_reg;

    logic [ACT_W-1:0] act_reg;
    logic [CNT_W-1:0] l_reg, r_reg;
    logic [VAL_W-1:0] v_reg, p_reg, m_reg, acc_reg, rc1_reg;
    logic             empty_reg, lok_reg;
    logic [NW-1:0]    tgt_reg;
    logic             tleaf_reg;
    logic             mx_ok_reg, pd_ok_reg;

    logic             out_vld_reg;
    logic [VAL_W-1:0] out_max_reg;
    logic             out_empty_reg;

    // ram ports
    logic              mx_we, pd_we;
    logic [NW-1:0]     mx_wn, pd_wn, mx_rn, pd_rn;
    logic [VAL_W-1:0]  mx_wd, pd_wd, mx_rd, pd_rd, mx_q, pd_q;
    logic              clr_we;

    // request decode
    logic [CNT_W-1:0] n_act, l_in, r_in, r_clip;
    logic             l_ok_in, empty_in;

    // stack top
    logic [IX_W-1:0]  sp_m1, sp_ix;
    frame_t           top;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid, mid_p1;
    logic [NW-1:0]    top_c1, top_c2, tgt_c1, tgt_c2;
    logic [NW-1:0]    sel_node;
    logic             sel_leaf;

    always_comb begin
        if (element_count == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(element_count) > MAX_ELEMENTS) begin
            n_act = CNT_W'(MAX_ELEMENTS);
        end else begin
            n_act = element_count;
        end
        l_in     = CNT_W'(s_tdata[9:0]);
        r_in     = CNT_W'(s_tdata[19:10]);
        r_clip   = (r_in > n_act - CNT_W'(1)) ? n_act - CNT_W'(1) : r_in;
        l_ok_in  = l_in < n_act;
        empty_in = !l_ok_in || (l_in > r_clip);
    end

    always_comb begin
        sp_m1   = IX_W'(sp_reg - SP_W'(1));
        sp_ix   = IX_W'(sp_reg);
        top     = stk_reg[sp_m1];
        mid_sum = {1'b0, top.lo} + {1'b0, top.hi};
        mid     = mid_sum[CNT_W:1];
        mid_p1  = mid + CNT_W'(1);
        top_c1  = NW'({top.node, 1'b0} + (NW+1)'(1));
        top_c2  = NW'({top.node, 1'b0} + (NW+1)'(2));
        tgt_c1  = NW'({tgt_reg, 1'b0} + (NW+1)'(1));
        tgt_c2  = NW'({tgt_reg, 1'b0} + (NW+1)'(2));
        unique case (cmd.op)
            OP_PRD_C1: begin
                sel_node = top_c1;
                sel_leaf = (top.lo == mid);
            end
            OP_PRD_C2: begin
                sel_node = top_c2;
                sel_leaf = (mid_p1 == top.hi);
            end
            default: begin
                sel_node = top.node;
                sel_leaf = (top.lo == top.hi);
            end
        endcase
    end

    // effective read data, zero for nodes past the store
    assign mx_q = mx_ok_reg ? mx_rd : '0;
    assign pd_q = pd_ok_reg ? pd_rd : '0;

    always_comb begin
        mx_we  = 1'b0;
        pd_we  = 1'b0;
        clr_we = 1'b0;
        mx_wn  = top.node;
        pd_wn  = tgt_reg;
        mx_wd  = '0;
        pd_wd  = '0;
        mx_rn  = sel_node;
        pd_rn  = sel_node;
        unique case (cmd.op)
            OP_CLEAR:  clr_we = 1'b1;
            OP_PAPPLY: begin
                mx_we = 1'b1;
                mx_wn = tgt_reg;
                mx_wd = m_reg + p_reg;
                pd_we = 1'b1;
                pd_wn = tgt_reg;
                pd_rn = tgt_c1;
            end
            OP_PC1: begin
                pd_we = 1'b1;
                pd_wn = tgt_c1;
                pd_wd = pd_q + p_reg;
                pd_rn = tgt_c2;
            end
            OP_PC2: begin
                pd_we = 1'b1;
                pd_wn = tgt_c2;
                pd_wd = pd_q + p_reg;
            end
            OP_LEAFWR: begin
                mx_we = 1'b1;
                mx_wd = v_reg;
            end
            OP_RC1: mx_rn = top_c1;
            OP_RC2: mx_rn = top_c2;
            OP_RCW: begin
                mx_we = 1'b1;
                mx_wd = smax(rc1_reg, mx_q);
            end
            default: ;
        endcase
    end

    lstrm_ram #(.WIDTH(VAL_W), .DEPTH(NODE_COUNT)) u_max_ram (
        .clk   (aclk),
        .we    (clr_we || (mx_we && ({1'b0, mx_wn} < NODE_LIM))),
        .waddr (clr_we ? clr_reg : NODE_W'(mx_wn)),
        .wdata (mx_wd),
        .raddr (NODE_W'(mx_rn)),
        .rdata (mx_rd)
    );

    lstrm_ram #(.WIDTH(VAL_W), .DEPTH(NODE_COUNT)) u_pend_ram (
        .clk   (aclk),
        .we    (clr_we || (pd_we && ({1'b0, pd_wn} < NODE_LIM))),
        .waddr (clr_we ? clr_reg : NODE_W'(pd_wn)),
        .wdata (pd_wd),
        .raddr (NODE_W'(pd_rn)),
        .rdata (pd_rd)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg      <= '0;
            clr_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_CLEAR) begin
                clr_reg <= clr_reg + NODE_W'(1);
            end
            unique case (cmd.op)
                OP_START:                          sp_reg <= SP_W'(1);
                OP_DESCEND, OP_PUSH_C1, OP_PUSH_C2: sp_reg <= sp_reg + SP_W'(1);
                OP_POP:                            sp_reg <= sp_reg - SP_W'(1);
                default: ;
            endcase
            if (cmd.op == OP_OUT) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        mx_ok_reg <= {1'b0, mx_rn} < NODE_LIM;
        pd_ok_reg <= {1'b0, pd_rn} < NODE_LIM;
        unique case (cmd.op)
            OP_START: begin
                act_reg    <= s_tuser;
                l_reg      <= l_in;
                r_reg      <= r_clip;
                v_reg      <= s_tdata[51:20];
                empty_reg  <= empty_in;
                lok_reg    <= l_ok_in;
                acc_reg    <= INT_MIN;
                stk_reg[0] <= '{node: '0, lo: '0, hi: n_act - CNT_W'(1), stage: STG_ENTER};
            end
            OP_PRD_TOP, OP_PRD_C1, OP_PRD_C2: begin
                tgt_reg   <= sel_node;
                tleaf_reg <= sel_leaf;
            end
            OP_PGET: begin
                p_reg <= pd_q;
                m_reg <= mx_q;
            end
            OP_PSETV:  p_reg <= v_reg;
            OP_PAPPLY: m_reg <= m_reg + p_reg;
            OP_DESCEND: begin
                if (l_reg <= mid) begin
                    stk_reg[sp_ix] <= '{node: top_c1, lo: top.lo, hi: mid, stage: STG_ENTER};
                end else begin
                    stk_reg[sp_ix] <= '{node: top_c2, lo: mid_p1, hi: top.hi, stage: STG_ENTER};
                end
            end
            OP_PUSH_C1: begin
                stk_reg[sp_m1].stage <= STG_LEFT;
                stk_reg[sp_ix] <= '{node: top_c1, lo: top.lo, hi: mid, stage: STG_ENTER};
            end
            OP_PUSH_C2: begin
                stk_reg[sp_m1].stage <= STG_RIGHT;
                stk_reg[sp_ix] <= '{node: top_c2, lo: mid_p1, hi: top.hi, stage: STG_ENTER};
            end
            OP_ACC: acc_reg <= smax(acc_reg, m_reg);
            OP_RC2: rc1_reg <= mx_q;
            OP_OUT: begin
                out_max_reg   <= acc_reg;
                out_empty_reg <= empty_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        sts.clear_done = (clr_reg == CLR_LAST);
        sts.do_set     = (act_reg == ACT_SET) && lok_reg;
        sts.do_add     = (act_reg == ACT_ADD) && !empty_reg;
        sts.do_query   = (act_reg == ACT_QUERY);
        sts.q_empty    = empty_reg;
        sts.p_zero     = (p_reg == '0);
        sts.tgt_leaf   = tleaf_reg;
        sts.top_leaf   = (top.lo == top.hi);
        sts.disjoint   = (r_reg < top.lo) || (top.hi < l_reg);
        sts.covered    = (l_reg <= top.lo) && (top.hi <= r_reg);
        sts.stage      = top.stage;
        sts.sp_one     = (sp_reg == SP_W'(1));
        sts.out_busy   = out_vld_reg && !m_tready;
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_max_reg;
    assign m_tuser[0] = out_empty_reg;

endmodule

// ===== src/lazy_segment_tree_range_max.sv =====
`timescale 1ns / 1ps
// operation: a set pushes pending adds down at each tree level going down and recomputes
//   each ancestor going up; a range add or query visits up to about four nodes per level,
//   each node step paced by the single read and write port of each node memory
// throughput: one item at a time; a query result waits in an output register
// reset: synchronous, active low; then a clearing pass zeroes both node memories,
//   during which no item is accepted (register writes still taken)
`include "assert_macros.svh"
module lazy_segment_tree_range_max
    import lstrm_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int NODE_COUNT   = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // index_low[9:0], index_high[19:10], value[51:20]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // max_value[31:0]
    output logic [0:0]  m_tuser,   // range_empty[0]
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t             cmd;
    sts_t             sts;
    logic [CNT_W-1:0] ec_reg;
    logic             ec_sel;

    // single register: element_count at byte address 0
    assign ec_sel = (paddr[2] == 1'b0);
    assign pready = 1'b1;
    assign prdata = ec_sel ? 32'(ec_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ec_reg <= CNT_RST;
        end else if (psel && penable && pwrite && pready && ec_sel) begin
            ec_reg <= pwdata[CNT_W-1:0];
        end
    end

    // sequencer: walks the tree one node step at a time
    lstrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // node memories, frame stack, request and result registers
    lstrm_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .NODE_COUNT   (NODE_COUNT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .element_count (ec_reg),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

    // no item taken during the clearing pass
    `ASSERT_IMPL(a_clear_blocks, aclk, aresetn, cmd.op == OP_CLEAR, !s_tready,
                 "item taken while clearing")
    // a work item only starts on an accepted item
    `ASSERT_IMPL(a_start_on_accept, aclk, aresetn, cmd.op == OP_START,
                 s_tvalid && s_tready, "start without accept")
    // maximum only gathered from fully covered nodes
    `ASSERT_IMPL(a_acc_covered, aclk, aresetn, cmd.op == OP_ACC,
                 sts.covered && !sts.disjoint, "partial node gathered")
    // empty range result carries the most negative value
    `ASSERT_IMPL(a_empty_min, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == INT_MIN,
                 "empty result not minimum")
    // a loaded result is presented next cycle
    `ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.op == OP_OUT, m_tvalid,
                 "result not presented")

endmodule
